// ===== hdl/wdrd_pkg.sv =====
// shared types and constants for the word delta run-length decoder
// used by wdrd_parser and word_delta_rle_decode; no dependencies

package wdrd_pkg;

  // result kinds, carried on the output tuser
  localparam logic [1:0] KIND_WORD      = 2'd0;
  localparam logic [1:0] KIND_LAST_BYTE = 2'd1;
  localparam logic [1:0] KIND_END       = 2'd2;
  localparam logic [1:0] KIND_UNUSED    = 2'd3;

  // opcode selector sits in the top two bits of the 16-bit opcode
  localparam int unsigned OP_SEL_LSB = 14;
  localparam logic [1:0] OP_PACKETS   = 2'd0;
  localparam logic [1:0] OP_IGNORED   = 2'd1;
  localparam logic [1:0] OP_LAST_BYTE = 2'd2;
  localparam logic [1:0] OP_LINE_SKIP = 2'd3;

  localparam int unsigned FW_W = 13;

  // one decoded write command
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] row;
    logic [15:0] column;
    logic [15:0] pixel_word;
    logic [7:0]  repeat_count;
    logic        chunk_end;
  } wdrd_result_t;

endpackage

// ===== hdl/wdrd_parser.sv =====
// byte-wise chunk parser: phase register, line/packet/word counters and
// the per-byte next-state and result logic; depends on wdrd_pkg

module wdrd_parser import wdrd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      chunk_byte,
  input  logic            chunk_start,
  input  logic [FW_W-1:0] frame_width,
  output logic            res_valid,
  output wdrd_result_t    res
);

  typedef enum logic [3:0] {
    PH_LC_LO, PH_LC_HI, PH_OP_LO, PH_OP_HI, PH_SKIP, PH_COUNT,
    PH_LIT_LO, PH_LIT_HI, PH_REP_LO, PH_REP_HI, PH_DONE
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [15:0] lines_left, lines_left_next;
  logic [15:0] current_row, current_row_next;
  logic [15:0] packets_left, packets_left_next;
  logic [15:0] current_column, current_column_next;
  logic [7:0]  words_left, words_left_next;
  logic [7:0]  held_byte, held_byte_next;

  // state as seen by this byte: a chunk start clears everything first
  phase_t      ph;
  logic [15:0] lines_e, row_e, packets_e, col_e;
  logic [7:0]  words_e, held_e;
  logic [15:0] word_in;
  logic [15:0] lines_dec, packets_dec;
  logic [7:0]  words_dec;
  logic [7:0]  neg_count;
  logic [1:0]  op_sel;

  assign ph        = chunk_start ? PH_LC_LO : parse_phase;
  assign lines_e   = chunk_start ? 16'd0 : lines_left;
  assign row_e     = chunk_start ? 16'd0 : current_row;
  assign packets_e = chunk_start ? 16'd0 : packets_left;
  assign col_e     = chunk_start ? 16'd0 : current_column;
  assign words_e   = chunk_start ? 8'd0 : words_left;
  assign held_e    = chunk_start ? 8'd0 : held_byte;

  assign word_in     = {chunk_byte, held_e};
  assign lines_dec   = lines_e - 16'd1;
  assign packets_dec = packets_e - 16'd1;
  assign words_dec   = words_e - 8'd1;
  assign neg_count   = 8'd0 - chunk_byte;
  assign op_sel      = word_in[OP_SEL_LSB +: 2];

  // next state and result for one byte
  always_comb begin
    parse_phase_next    = ph;
    lines_left_next     = lines_e;
    current_row_next    = row_e;
    packets_left_next   = packets_e;
    current_column_next = col_e;
    words_left_next     = words_e;
    held_byte_next      = held_e;
    res_valid           = 1'b0;
    res                 = '0;
    res.kind            = KIND_END;

    case (ph)
      PH_LC_LO: begin
        held_byte_next   = chunk_byte;
        parse_phase_next = PH_LC_HI;
      end
      PH_LC_HI: begin
        lines_left_next  = word_in;
        current_row_next = 16'd0;
        if (word_in == 16'd0) begin
          parse_phase_next = PH_DONE;
          res_valid        = 1'b1;
          res.chunk_end    = 1'b1;
        end else begin
          parse_phase_next = PH_OP_LO;
        end
      end
      PH_OP_LO, PH_LIT_LO, PH_REP_LO: begin
        held_byte_next = chunk_byte;
        case (ph)
          PH_OP_LO:  parse_phase_next = PH_OP_HI;
          PH_LIT_LO: parse_phase_next = PH_LIT_HI;
          default:   parse_phase_next = PH_REP_HI;
        endcase
      end
      PH_OP_HI: begin
        case (op_sel)
          OP_PACKETS: begin
            packets_left_next   = word_in;
            current_column_next = 16'd0;
            if (word_in == 16'd0) begin
              // empty line: finish it right away
              current_row_next = row_e + 16'd1;
              lines_left_next  = lines_dec;
              if (lines_dec == 16'd0) begin
                parse_phase_next = PH_DONE;
                res_valid        = 1'b1;
                res.chunk_end    = 1'b1;
              end else begin
                parse_phase_next = PH_OP_LO;
              end
            end else begin
              parse_phase_next = PH_SKIP;
            end
          end
          OP_LAST_BYTE: begin
            parse_phase_next = PH_OP_LO;
            res_valid        = 1'b1;
            res.kind         = KIND_LAST_BYTE;
            res.row          = row_e;
            res.column       = {{(16-FW_W){1'b0}}, frame_width} - 16'd1;
            res.pixel_word   = {8'd0, word_in[7:0]};
            res.repeat_count = 8'd1;
          end
          OP_LINE_SKIP: begin
            parse_phase_next = PH_OP_LO;
            current_row_next = row_e - word_in;
          end
          default: begin
            parse_phase_next = PH_OP_LO;
          end
        endcase
      end
      PH_SKIP: begin
        current_column_next = col_e + {8'd0, chunk_byte};
        parse_phase_next    = PH_COUNT;
      end
      PH_COUNT: begin
        if (chunk_byte == 8'd0) begin
          // zero-count packet makes no write; it ends the packet, maybe the line and chunk
          packets_left_next = packets_dec;
          if (packets_dec == 16'd0) begin
            current_row_next = row_e + 16'd1;
            lines_left_next  = lines_dec;
            if (lines_dec == 16'd0) begin
              parse_phase_next = PH_DONE;
              res_valid        = 1'b1;
              res.chunk_end    = 1'b1;
            end else begin
              parse_phase_next = PH_OP_LO;
            end
          end else begin
            parse_phase_next = PH_SKIP;
          end
        end else if (!chunk_byte[7]) begin
          words_left_next  = chunk_byte;
          parse_phase_next = PH_LIT_LO;
        end else begin
          words_left_next  = neg_count;
          parse_phase_next = PH_REP_LO;
        end
      end
      PH_LIT_HI, PH_REP_HI: begin
        res_valid      = 1'b1;
        res.kind       = KIND_WORD;
        res.row        = row_e;
        res.column     = col_e;
        res.pixel_word = word_in;
        if (ph == PH_LIT_HI) begin
          res.repeat_count    = 8'd1;
          current_column_next = col_e + 16'd2;
          words_left_next     = words_dec;
        end else begin
          res.repeat_count    = words_e;
          current_column_next = col_e + {7'd0, words_e, 1'b0};
          words_left_next     = 8'd0;
        end
        if (ph == PH_LIT_HI && words_dec != 8'd0) begin
          parse_phase_next = PH_LIT_LO;
        end else begin
          // end of packet, maybe of line and chunk
          packets_left_next = packets_dec;
          if (packets_dec == 16'd0) begin
            current_row_next = row_e + 16'd1;
            lines_left_next  = lines_dec;
            if (lines_dec == 16'd0) begin
              parse_phase_next = PH_DONE;
              res.chunk_end    = 1'b1;
            end else begin
              parse_phase_next = PH_OP_LO;
            end
          end else begin
            parse_phase_next = PH_SKIP;
          end
        end
      end
      default: begin
        parse_phase_next = PH_DONE;
      end
    endcase
  end

  // parser state, advanced once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_LC_LO;
      lines_left     <= 16'd0;
      current_row    <= 16'd0;
      packets_left   <= 16'd0;
      current_column <= 16'd0;
      words_left     <= 8'd0;
      held_byte      <= 8'd0;
    end else if (step) begin
      parse_phase    <= parse_phase_next;
      lines_left     <= lines_left_next;
      current_row    <= current_row_next;
      packets_left   <= packets_left_next;
      current_column <= current_column_next;
      words_left     <= words_left_next;
      held_byte      <= held_byte_next;
    end
  end

endmodule

// ===== hdl/word_delta_rle_decode.sv =====
// A byte in the input register is parsed combinationally; its command is
// registered as the byte advances. Throughput: one byte per cycle unless output
// backpressure stalls the input register; the only loop is the parser state
// update, which resolves within the cycle between the input and result registers.
// A byte that makes no command still takes a parser step. Reset (rst, synchronous)
// clears the parser and both stage valids and sets frame_width to 320.

module word_delta_rle_decode import wdrd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  // configuration
  input  logic            cfg_wr_en,
  input  logic [FW_W-1:0] cfg_wr_data,   // frame_width
  // byte stream in
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,       // [7:0] chunk_byte
  input  logic [0:0]      s_tuser,       // [0] chunk_start
  // command stream out
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [55:0]     m_tdata,       // [15:0] row, [31:16] column,
                                         // [47:32] pixel_word, [55:48] repeat_count
  output logic [1:0]      m_tuser,       // [1:0] write_kind
  output logic            m_tlast        // chunk_end
);

  logic [FW_W-1:0] frame_width;
  logic            in_valid;
  logic [7:0]      in_byte;
  logic            in_start;
  logic            advance;
  logic            res_valid;
  wdrd_result_t    res;
  wdrd_result_t    out_res;

  // the held byte moves on when the result register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FW_W'(320);
    end else if (cfg_wr_en) begin
      frame_width <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser[0];
    end
  end

  wdrd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .chunk_byte  (in_byte),
    .chunk_start (in_start),
    .frame_width (frame_width),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.repeat_count, out_res.pixel_word, out_res.column, out_res.row};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.chunk_end;

  // a chunk-end-only command always closes the chunk
  a_end_kind_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_END |-> m_tlast)
    else $error("end-only command without chunk_end");

  // kind code three is never produced
  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != KIND_UNUSED)
    else $error("unused write kind on output");

  // every write command fills at least one word
  a_write_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_END |-> m_tdata[55:48] != 8'd0)
    else $error("write command with zero repeat count");

  // a byte held while the output stalls is not dropped
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("held input byte lost during stall");

endmodule
